// File: hdl/arth_pkg.sv
// arth_pkg: shared types and constants for the auth response tlv parser
// used by arth_core, arth_outq and auth_response_tlv_parser; no dependencies

package arth_pkg;

  localparam int UserMaxDefault = 32;

  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);

  localparam logic [7:0] TagDigest = 8'h00;
  localparam logic [7:0] TagUser   = 8'h01;
  localparam logic [7:0] TagNonce  = 8'h02;
  localparam logic [7:0] FixedLen  = 8'd16;

  typedef enum logic [1:0] {
    PH_TAG = 2'd0,
    PH_LEN = 2'd1,
    PH_VAL = 2'd2
  } arth_phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TAG   = 2'd1,
    ST_LEN   = 2'd2,
    ST_TRUNC = 2'd3
  } arth_status_t;

  typedef enum logic {
    KIND_VALUE  = 1'b0,
    KIND_STATUS = 1'b1
  } arth_kind_t;

  // one result item
  typedef struct packed {
    arth_kind_t   kind;
    logic [1:0]   field_id;
    logic [4:0]   byte_index;
    logic [7:0]   value_byte;
    arth_status_t parse_status;
    logic [5:0]   user_length;
    logic         last_item;
  } arth_item_t;

  // up to two result items from one input item, earlier item first
  typedef struct packed {
    logic       first_vld;
    arth_item_t first;
    logic       second_vld;
    arth_item_t second;
  } arth_push_t;

endpackage

// File: hdl/arth_core.sv
// arth_core: tag/length/value parser state and per-byte step logic
// depends on arth_pkg

module arth_core import arth_pkg::*; #(
  parameter int USER_MAX = UserMaxDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] header_byte,
  input  logic       final_byte,
  output arth_push_t push
);

  arth_phase_t  phase, phase_next;
  logic [1:0]   cur_tag, cur_tag_next;
  logic [7:0]   bytes_left, bytes_left_next;
  logic [4:0]   vpos, vpos_next;
  arth_status_t err, err_next;
  logic [5:0]   ulen, ulen_next;

  logic         good_len;
  logic         val_vld;
  arth_item_t   val_item;
  arth_item_t   st_item;

  always_comb begin
    phase_next      = phase;
    cur_tag_next    = cur_tag;
    bytes_left_next = bytes_left;
    vpos_next       = vpos;
    err_next        = err;
    ulen_next       = ulen;
    val_vld         = 1'b0;
    good_len        = 1'b0;

    val_item              = '0;
    val_item.kind         = KIND_VALUE;
    val_item.field_id     = cur_tag;
    val_item.byte_index   = vpos;
    val_item.value_byte   = header_byte;
    val_item.parse_status = ST_OK;

    if (err == ST_OK) begin
      case (phase)
        PH_TAG: begin
          if (header_byte > TagNonce) begin
            err_next = ST_TAG;
          end else begin
            cur_tag_next = header_byte[1:0];
            phase_next   = PH_LEN;
          end
        end
        PH_LEN: begin
          if (cur_tag == TagUser[1:0]) begin
            good_len = ({1'b0, header_byte} <= 9'(USER_MAX));
          end else begin
            good_len = (header_byte == FixedLen);
          end
          if (!good_len) begin
            err_next = ST_LEN;
          end else if (header_byte == 8'd0) begin
            ulen_next  = 6'd0;
            phase_next = PH_TAG;
          end else begin
            bytes_left_next = header_byte;
            vpos_next       = 5'd0;
            phase_next      = PH_VAL;
          end
        end
        PH_VAL: begin
          val_vld         = 1'b1;
          bytes_left_next = bytes_left - 8'd1;
          vpos_next       = vpos + 5'd1;
          if (bytes_left == 8'd1) begin
            if (cur_tag == TagUser[1:0]) begin
              ulen_next = {1'b0, vpos} + 6'd1;
            end
            phase_next = PH_TAG;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    // status item on the final byte
    st_item             = '0;
    st_item.kind        = KIND_STATUS;
    st_item.user_length = ulen_next;
    st_item.last_item   = 1'b1;
    if (err_next == ST_OK && phase_next != PH_TAG) begin
      st_item.parse_status = ST_TRUNC;
    end else begin
      st_item.parse_status = err_next;
    end

    if (final_byte) begin
      phase_next      = PH_TAG;
      cur_tag_next    = 2'd0;
      bytes_left_next = 8'd0;
      vpos_next       = 5'd0;
      err_next        = ST_OK;
      ulen_next       = 6'd0;
    end

    push.first_vld  = accept && (val_vld || final_byte);
    push.first      = val_vld ? val_item : st_item;
    push.second_vld = accept && val_vld && final_byte;
    push.second     = st_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG;
      cur_tag    <= 2'd0;
      bytes_left <= 8'd0;
      vpos       <= 5'd0;
      err        <= ST_OK;
      ulen       <= 6'd0;
    end else if (accept) begin
      phase      <= phase_next;
      cur_tag    <= cur_tag_next;
      bytes_left <= bytes_left_next;
      vpos       <= vpos_next;
      err        <= err_next;
      ulen       <= ulen_next;
    end
  end

endmodule

// File: hdl/arth_outq.sv
// arth_outq: small result queue, takes up to two items a cycle, gives one while out_rdy is high
// depends on arth_pkg

module arth_outq import arth_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arth_push_t push,
  output logic       room2,
  output logic       out_vld,
  input  logic       out_rdy,
  output arth_item_t out_item
);

  arth_item_t           slots [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr, rd_ptr;
  logic [OutPtrW:0]     cnt, cnt_next;
  logic                 pop;
  logic [1:0]           push_n;

  assign pop      = out_vld && out_rdy;
  assign out_vld  = (cnt != '0);
  assign out_item = slots[rd_ptr];
  assign room2    = (cnt <= (OutPtrW+1)'(OutDepth - 2));
  assign push_n   = {1'b0, push.first_vld} + {1'b0, push.second_vld};
  assign cnt_next = cnt + (OutPtrW+1)'(push_n) - (OutPtrW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.second_vld) begin
      slots[wr_ptr + OutPtrW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + OutPtrW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + OutPtrW'(1);
      end
      cnt <= cnt_next;
    end
  end

endmodule

// File: hdl/auth_response_tlv_parser.sv
// auth_response_tlv_parser: top level of the authentication response tlv parser
// depends on arth_pkg, arth_core, arth_outq
//
// channel  dir  tdata (low bit up)                              tuser       tlast
// s_*      in   header_byte[7:0]                                -           final_byte
// m_*      out  field_id[1:0] byte_index[4:0] value_byte[7:0]   item_kind   last_item
//               parse_status[1:0] user_length[5:0] zero pad
//
// one input item per cycle while s_tready is high; the parser step is combinational
// logic between the parser state registers and a 4-entry result queue
// an input item yields zero, one or two result items; the queue drains one per cycle while m_tready is high
// s_tready is high while the queue holds at most two items, so with m_tready low
// input stops once the queue holds three or more items; sustained rate is one item
// per cycle while m_tready is high and each byte gives at most one result
// rst (synchronous) returns the parser to expecting a tag and empties the queue

module auth_response_tlv_parser import arth_pkg::*; #(
  parameter int USER_MAX = UserMaxDefault
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // header_byte[7:0]
  input  logic        s_tlast,   // final_byte
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // field_id, byte_index, value_byte, parse_status,
                                 // user_length, one zero bit
  output logic [0:0]  m_tuser,   // item_kind
  output logic        m_tlast    // last_item
);

  logic       accept;
  arth_push_t push;
  arth_item_t out_item;

  assign accept = s_tvalid && s_tready;

  // parser state and per-byte step
  arth_core #(
    .USER_MAX (USER_MAX)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .header_byte (s_tdata),
    .final_byte  (s_tlast),
    .push        (push)
  );

  // result queue, decouples the output stall from input acceptance
  arth_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room2    (s_tready),
    .out_vld  (m_tvalid),
    .out_rdy  (m_tready),
    .out_item (out_item)
  );

  // pack fields, first field in the lowest bits
  assign m_tdata = {1'b0,
                    out_item.user_length,
                    out_item.parse_status,
                    out_item.value_byte,
                    out_item.byte_index,
                    out_item.field_id};
  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.last_item;

endmodule

// File: test/auth_response_tlv_parser_checker.sv
`timescale 1ns / 1ps
// auth_response_tlv_parser_checker: watches both item channels of the tlv parser,
// predicts the result items and compares them; depends on arth_pkg only

module auth_response_tlv_parser_checker import arth_pkg::*; #(
  parameter int USER_MAX = UserMaxDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          waiting
);

  localparam int ReportLimit = 10;

  // parser state as the block should hold it
  arth_phase_t  cur_phase;
  logic [1:0]   cur_tag;
  logic [7:0]   bytes_left;
  logic [4:0]   value_pos;
  arth_status_t cur_status;
  logic [5:0]   user_len;

  arth_item_t pending_items[$];
  arth_item_t got, want;
  int         mismatch_count = 0;

  assign errors = mismatch_count;

  function automatic string item_text(input arth_item_t it);
    return $sformatf("kind %0d field %0d index %0d value %02h status %0d ulen %0d last %0d",
                     it.kind, it.field_id, it.byte_index, it.value_byte,
                     it.parse_status, it.user_length, it.last_item);
  endfunction

  task automatic reset_parser();
    cur_phase  = PH_TAG;
    cur_tag    = '0;
    bytes_left = '0;
    value_pos  = '0;
    cur_status = ST_OK;
    user_len   = '0;
  endtask

  // one header byte in, zero to two result items queued
  task automatic parse_header_byte(input logic [7:0] hdr_byte, input logic fin);
    arth_item_t it;
    logic [4:0] idx;
    it = '0;
    if (cur_status == ST_OK) begin
      case (cur_phase)
        PH_TAG: begin
          if (hdr_byte > TagNonce) begin
            cur_status = ST_TAG;
          end else begin
            cur_tag   = hdr_byte[1:0];
            cur_phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if ((cur_tag == TagUser[1:0]) ? (hdr_byte > USER_MAX) : (hdr_byte != FixedLen)) begin
            cur_status = ST_LEN;
          end else if (hdr_byte == 8'd0) begin
            user_len  = '0;
            cur_phase = PH_TAG;
          end else begin
            bytes_left = hdr_byte;
            value_pos  = '0;
            cur_phase  = PH_VAL;
          end
        end
        default: begin
          it.kind       = KIND_VALUE;
          it.field_id   = cur_tag;
          it.byte_index = value_pos;
          it.value_byte = hdr_byte;
          pending_items.push_back(it);
          idx        = value_pos;
          value_pos  = value_pos + 5'd1;
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) begin
            if (cur_tag == TagUser[1:0]) user_len = 6'(idx) + 6'd1;
            cur_phase = PH_TAG;
          end
        end
      endcase
    end
    if (fin) begin
      if (cur_status == ST_OK && cur_phase != PH_TAG) cur_status = ST_TRUNC;
      it              = '0;
      it.kind         = KIND_STATUS;
      it.parse_status = cur_status;
      it.user_length  = user_len;
      it.last_item    = 1'b1;
      pending_items.push_back(it);
      reset_parser();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_parser();
      pending_items.delete();
    end else begin
      // results leave before this edge's input can add any
      if (m_tvalid && m_tready) begin
        got.kind         = arth_kind_t'(m_tuser[0]);
        got.field_id     = m_tdata[1:0];
        got.byte_index   = m_tdata[6:2];
        got.value_byte   = m_tdata[14:7];
        got.parse_status = arth_status_t'(m_tdata[16:15]);
        got.user_length  = m_tdata[22:17];
        got.last_item    = m_tlast;
        if (pending_items.size() == 0) begin
          if (mismatch_count < ReportLimit)
            $display("%0t: unexpected result item: %s", $time, item_text(got));
          mismatch_count++;
        end else begin
          want = pending_items.pop_front();
          if (got.kind != want.kind || got.field_id != want.field_id ||
              got.byte_index != want.byte_index || got.value_byte != want.value_byte ||
              got.parse_status != want.parse_status ||
              got.user_length != want.user_length || got.last_item != want.last_item ||
              m_tdata[23] !== 1'b0) begin
            if (mismatch_count < ReportLimit)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s pad %b", $time,
                       item_text(want), item_text(got), m_tdata[23]);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) parse_header_byte(s_tdata, s_tlast);
    end
    waiting <= pending_items.size();
  end

endmodule

// File: test/auth_response_tlv_parser_test.sv
`timescale 1ns / 1ps
// auth_response_tlv_parser_test: drives header bytes into the tlv parser and gives the verdict
// depends on arth_pkg, auth_response_tlv_parser and auth_response_tlv_parser_checker

module auth_response_tlv_parser_test import arth_pkg::*;;

  localparam int RunLimit     = 500000;  // cycles before the run is declared hung
  localparam int SettleCycles = 20;      // quiet cycles after the last expected item
  localparam int PhaseItems   = 190;     // random input items per idling phase

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  int errors;
  int waiting;

  // idling percentages for the current phase
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent = 0;

  // bytes of the header being built, final flag goes on the last one
  logic [7:0] header_bytes[$];

  always #2 clk = ~clk;

  auth_response_tlv_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  auth_response_tlv_parser_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .waiting  (waiting)
  );

  // receiver stalls at random, one decision per cycle
  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // sender gap of geometric length, valid dropped only while idle
  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // present one item and hold it until the handshake
  task automatic send_byte(input logic [7:0] hdr_byte, input logic fin);
    sender_gap();
    s_tvalid <= 1'b1;
    s_tdata  <= hdr_byte;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_header();
    foreach (header_bytes[i]) send_byte(header_bytes[i], i == header_bytes.size() - 1);
  endtask

  // hold off input until every predicted item has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // tag, length and random value bytes
  task automatic add_entry(input logic [7:0] tag, input logic [7:0] len);
    header_bytes.push_back(tag);
    header_bytes.push_back(len);
    repeat (len) header_bytes.push_back(8'($urandom));
  endtask

  // well-formed header of one to three entries, mostly short user ids
  task automatic build_header();
    int pick;
    header_bytes.delete();
    repeat ($urandom_range(3, 1)) begin
      pick = $urandom_range(19);
      if (pick < 3) add_entry(TagDigest, FixedLen);
      else if (pick < 6) add_entry(TagNonce, FixedLen);
      else if (pick == 6) add_entry(TagUser, 8'(UserMaxDefault));
      else if (pick < 10) add_entry(TagUser, 8'd0);
      else add_entry(TagUser, 8'($urandom_range(6, 1)));
    end
  endtask

  initial begin
    repeat (RunLimit) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int r;
    int cut;
    int target;
    logic [7:0] bad;
    logic [7:0] tag;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    // unknown tag on the final byte itself
    send_byte(8'd3, 1'b1);
    // unknown tag, later bytes ignored up to the final one
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    // empty user id ends the header cleanly
    send_byte(TagUser, 1'b0);
    send_byte(8'd0, 1'b1);
    // user id one byte over the limit, bad length
    send_byte(TagUser, 1'b0);
    send_byte(8'(UserMaxDefault + 1), 1'b0);
    send_byte(8'haa, 1'b1);
    // short digest length arriving as the final byte
    send_byte(TagDigest, 1'b0);
    send_byte(8'd15, 1'b1);
    // nonce with the largest length byte
    send_byte(TagNonce, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b1);
    // lone tag at the end, truncated while expecting a length
    send_byte(TagNonce, 1'b1);
    // final flag on a value byte: value item, then status item
    send_byte(TagUser, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    // user id cut short inside its value
    send_byte(TagUser, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(8'h5a, 1'b1);
    wait_drained();

    // random part over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 65;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 65;
        end
        default: begin
          idle_pct  = 34;
          stall_pct = 34;
        end
      endcase
      target = sent + PhaseItems;
      while (sent < target) begin
        r = $urandom_range(99);
        build_header();
        if (r < 60) begin
          // well-formed header as built
        end else if (r < 72) begin
          // truncate anywhere before the natural end
          if (header_bytes.size() > 1) begin
            cut = $urandom_range(header_bytes.size() - 1, 1);
            while (header_bytes.size() > cut) void'(header_bytes.pop_back());
          end
        end else if (r < 80) begin
          // unknown tag, then trailing bytes that must be ignored
          header_bytes.push_back(8'($urandom_range(255, 3)));
          repeat ($urandom_range(4, 0)) header_bytes.push_back(8'($urandom));
        end else if (r < 90) begin
          // bad length for a random tag, then ignored bytes
          tag = 8'($urandom_range(2, 0));
          if (tag == TagUser) begin
            bad = 8'($urandom_range(255, UserMaxDefault + 1));
          end else begin
            bad = 8'($urandom);
            while (bad == FixedLen) bad = 8'($urandom);
          end
          header_bytes.push_back(tag);
          header_bytes.push_back(bad);
          repeat ($urandom_range(4, 0)) header_bytes.push_back(8'($urandom));
        end else begin
          // plain noise
          header_bytes.delete();
          repeat ($urandom_range(8, 1)) header_bytes.push_back(8'($urandom));
        end
        send_header();
      end
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
